// ===== rtl/dmmts_pkg.sv =====
// ---------------------------------------------------------------------------
// dmmts_pkg: shared types and constants for duration statistics
// Request and statistics records, mode codes, time constants and the
// lexicographic duration compare.
// ---------------------------------------------------------------------------
package dmmts_pkg;

  // request modes, code 3 leaves the statistics as they are
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_MERGE  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  localparam int unsigned IN_DATA_W  = 288;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 232;
  localparam int unsigned STATS_W    = 226;

  // time constants; the per-second and two-second nanosecond ones are 31 bits wide to match the nanosecond adder
  localparam logic [30:0] NANOS_PER_SEC  = 31'd1000000000;
  localparam logic [30:0] TWO_SECS_NANOS = 31'd2000000000;
  localparam logic [29:0] NANOS_MAX      = 30'd999999999;
  localparam logic [39:0] SECS_MAX       = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

  // one request as held in the input stage
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sample_secs;
    logic [29:0] sample_nanos;
    logic [31:0] other_count;
    logic [39:0] other_total_secs;
    logic [29:0] other_total_nanos;
    logic [31:0] other_min_secs;
    logic [29:0] other_min_nanos;
    logic [31:0] other_max_secs;
    logic [29:0] other_max_nanos;
  } item_t;

  // running statistics, also the result record
  typedef struct packed {
    logic [29:0] sum_nanos;
    logic [39:0] sum_secs;
    logic [29:0] max_nanos;
    logic [31:0] max_secs;
    logic [29:0] min_nanos;
    logic [31:0] min_secs;
    logic [31:0] count;
  } stats_t;

  // a < b, seconds first, then nanoseconds
  function automatic logic dur_less(input logic [31:0] as, input logic [29:0] an,
                                    input logic [31:0] bs, input logic [29:0] bn);
    dur_less = (as < bs) || ((as == bs) && (an < bn));
  endfunction

endpackage

// ===== rtl/duration_min_max_total_stats_top.sv =====
// ---------------------------------------------------------------------------
// duration_min_max_total_stats_top: running duration statistics
// Keeps count, minimum, maximum and normalized total of durations and
// returns the statistics after every request.
// ---------------------------------------------------------------------------
// Each request on the slave stream (append a sample, merge a record, or
// clear) gives exactly one result on the master stream: the statistics as
// they stand after that request. A request is registered on entry, then
// applied to the statistics, and the updated statistics register is the
// result register, so a request passes the input register and then the
// statistics register; one request is taken every cycle while the master
// side keeps tready high. The update loop holds the compare, count add and
// 40-bit seconds add with nanosecond normalization. Durations compare
// seconds first, then nanoseconds; count and total saturate.
module duration_min_max_total_stats_top
  import dmmts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // sample_secs, sample_nanos, other_count, other_total_secs,
  // other_total_nanos, other_min_secs, other_min_nanos, other_max_secs,
  // other_max_nanos
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // mode
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // sample_count, min_secs, min_nanos, max_secs, max_nanos, sum_secs,
  // sum_nanos, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic   held_valid;
  logic   advance;
  item_t  item;
  stats_t stats;
  stats_t stats_next;

  // a held request moves on when the result slot is free or being taken
  assign advance = held_valid && (!m_tvalid || m_tready);

  // input register
  dmmts_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .held_valid (held_valid),
    .item       (item)
  );

  // update logic
  dmmts_update u_update (
    .cur  (stats),
    .item (item),
    .nxt  (stats_next)
  );

  // statistics register, doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else if (advance) begin
      stats <= stats_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= held_valid;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - STATS_W){1'b0}}, stats};

  // total nanoseconds always normalized
  a_nanos_norm: assert property (@(posedge clk) disable iff (rst)
    {1'b0, stats.sum_nanos} < NANOS_PER_SEC)
    else $error("total nanoseconds not normalized");

  // a waiting result holds the statistics
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(stats))
    else $error("statistics changed while result stalled");

  // clear empties count and total
  a_clear: assert property (@(posedge clk) disable iff (rst)
    advance && item.mode == MODE_CLEAR |=> stats.count == '0 && stats.sum_secs == '0)
    else $error("clear did not empty statistics");

  // append bumps the count by one below saturation
  a_append: assert property (@(posedge clk) disable iff (rst)
    advance && item.mode == MODE_APPEND && stats.count != COUNT_MAX
    |=> stats.count == $past(stats.count) + 32'd1)
    else $error("append count mismatch");

endmodule

// ===== rtl/dmmts_in_stage.sv =====
// ---------------------------------------------------------------------------
// dmmts_in_stage: input register of the statistics block
// Captures one request from the slave stream and holds it until the
// update stage takes it.
// ---------------------------------------------------------------------------
module dmmts_in_stage
  import dmmts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [IN_USER_W-1:0] s_tuser,
  input  logic                 advance,
  output logic                 held_valid,
  output item_t                item
);

  // room when empty or when the held request moves on this cycle, none in reset
  assign s_tready = !rst && (!held_valid || advance);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  // request payload, unpacked from the bus
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode              <= s_tuser;
      item.sample_secs       <= s_tdata[31:0];
      item.sample_nanos      <= s_tdata[61:32];
      item.other_count       <= s_tdata[93:62];
      item.other_total_secs  <= s_tdata[133:94];
      item.other_total_nanos <= s_tdata[163:134];
      item.other_min_secs    <= s_tdata[195:164];
      item.other_min_nanos   <= s_tdata[225:196];
      item.other_max_secs    <= s_tdata[257:226];
      item.other_max_nanos   <= s_tdata[287:258];
    end
  end

endmodule

// ===== rtl/dmmts_update.sv =====
// ---------------------------------------------------------------------------
// dmmts_update: next-statistics logic
// Applies one request to the current statistics: min/max compares,
// saturating count, normalized and saturating total.
// ---------------------------------------------------------------------------
module dmmts_update
  import dmmts_pkg::*;
(
  input  stats_t cur,
  input  item_t  item,
  output stats_t nxt
);

  stats_t      upd;
  logic        do_add;
  logic [39:0] base_secs;
  logic [29:0] base_nanos;
  logic [39:0] add_secs;
  logic [29:0] add_nanos;
  logic [31:0] count_inc;
  logic [32:0] count_sum;
  logic [31:0] count_sat;
  logic [30:0] nano_sum;
  logic [30:0] nano_norm;
  logic [1:0]  nano_carry;
  logic [41:0] secs_sum;
  logic [39:0] total_secs;
  logic [29:0] total_nanos;

  // saturating count add
  assign count_sum = {1'b0, cur.count} + {1'b0, count_inc};
  assign count_sat = count_sum[32] ? COUNT_MAX : count_sum[31:0];

  // mode decode, min/max and count
  always_comb begin
    upd        = cur;
    do_add     = 1'b0;
    base_secs  = cur.sum_secs;
    base_nanos = cur.sum_nanos;
    add_secs   = item.other_total_secs;
    add_nanos  = item.other_total_nanos;
    count_inc  = item.other_count;
    case (item.mode)
      MODE_APPEND: begin
        add_secs  = {8'd0, item.sample_secs};
        add_nanos = item.sample_nanos;
        count_inc = 32'd1;
        do_add    = 1'b1;
        upd.count = count_sat;
        if (cur.count == '0 ||
            dur_less(item.sample_secs, item.sample_nanos, cur.min_secs, cur.min_nanos)) begin
          upd.min_secs  = item.sample_secs;
          upd.min_nanos = item.sample_nanos;
        end
        if (cur.count == '0 ||
            dur_less(cur.max_secs, cur.max_nanos, item.sample_secs, item.sample_nanos)) begin
          upd.max_secs  = item.sample_secs;
          upd.max_nanos = item.sample_nanos;
        end
      end
      MODE_MERGE: begin
        if (cur.count == '0) begin
          // empty own record: copy the other one, total from zero
          upd.count     = item.other_count;
          upd.min_secs  = item.other_min_secs;
          upd.min_nanos = item.other_min_nanos;
          upd.max_secs  = item.other_max_secs;
          upd.max_nanos = item.other_max_nanos;
          base_secs     = '0;
          base_nanos    = '0;
          do_add        = 1'b1;
        end else if (item.other_count != '0) begin
          upd.count = count_sat;
          do_add    = 1'b1;
          if (dur_less(item.other_min_secs, item.other_min_nanos,
                       cur.min_secs, cur.min_nanos)) begin
            upd.min_secs  = item.other_min_secs;
            upd.min_nanos = item.other_min_nanos;
          end
          if (dur_less(cur.max_secs, cur.max_nanos,
                       item.other_max_secs, item.other_max_nanos)) begin
            upd.max_secs  = item.other_max_secs;
            upd.max_nanos = item.other_max_nanos;
          end
        end
      end
      MODE_CLEAR: begin
        upd.count     = '0;
        upd.sum_secs  = '0;
        upd.sum_nanos = '0;
      end
      default: begin
      end
    endcase
  end

  // total: nanosecond add, normalize by at most two seconds, saturate
  always_comb begin
    nano_sum = {1'b0, base_nanos} + {1'b0, add_nanos};
    if (nano_sum >= TWO_SECS_NANOS) begin
      nano_norm  = nano_sum - TWO_SECS_NANOS;
      nano_carry = 2'd2;
    end else if (nano_sum >= NANOS_PER_SEC) begin
      nano_norm  = nano_sum - NANOS_PER_SEC;
      nano_carry = 2'd1;
    end else begin
      nano_norm  = nano_sum;
      nano_carry = 2'd0;
    end
    secs_sum = {2'b00, base_secs} + {2'b00, add_secs} + {40'd0, nano_carry};
    if (secs_sum[41:40] != 2'b00) begin
      total_secs  = SECS_MAX;
      total_nanos = NANOS_MAX;
    end else begin
      total_secs  = secs_sum[39:0];
      total_nanos = nano_norm[29:0];
    end
  end

  // final record
  always_comb begin
    nxt = upd;
    if (do_add) begin
      nxt.sum_secs  = total_secs;
      nxt.sum_nanos = total_nanos;
    end
  end

endmodule
